### hw/rtl/pfa_pkg.sv
package pfa_pkg;

    // Sizes of the managed region.
    localparam int MAX_FRAMES  = 1024;
    localparam int FRAME_BYTES = 4096;
    localparam int PAGE_SHIFT  = $clog2(FRAME_BYTES);

    // The used marks are kept in words of WORD_BITS marks each.
    localparam int WORD_BITS   = 32;
    localparam int WORDS       = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int WORD_IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FRAME_IDX_W = WORD_IDX_W + BIT_IDX_W;
    localparam int COUNT_W     = FRAME_IDX_W + 1;

    // Field widths.
    localparam int ADDR_W   = 32;
    localparam int FLAGS_W  = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PAGES_W  = ADDR_W - PAGE_SHIFT;

    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Result status codes.
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_BADADDR = 2'd2;
    localparam status_t ST_NOTUSED = 2'd3;

    // Request modes.
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_REGION_BASE = 2'd0;
    localparam cfg_idx_t CFG_MEMORY_TOP  = 2'd1;

    // Register reset values.
    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] MEMORY_TOP_RST  = 32'h0050_0000;

    localparam logic [ADDR_W-1:0] PRESENT_BIT = 32'h0000_0001;

endpackage

### hw/rtl/pfa_if.sv
// Allocate or release request channel.
interface pfa_req_if;
    import pfa_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [FLAGS_W-1:0] entry_flags;
    logic [ADDR_W-1:0]  page_address;

    modport source (output valid, mode, entry_flags, page_address, input ready);
    modport sink   (input valid, mode, entry_flags, page_address, output ready);
endinterface

// Result channel.
interface pfa_rsp_if;
    import pfa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] table_entry;
    status_t           status;

    modport source (output valid, table_entry, status, input ready);
    modport sink   (input valid, table_entry, status, output ready);
endinterface

// Configuration write channel.
interface pfa_cfg_if;
    import pfa_pkg::*;

    logic              valid;
    logic              ready;
    cfg_idx_t          index;
    logic [ADDR_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/page_frame_allocator_unit.sv
// First-fit page frame allocator.
// The req channel carries allocate (mode 0) and release (mode 1) requests; each
// request yields exactly one result on the rsp channel: a page table entry
// (frame address | present bit | flags) and a status code. The cfg channel
// writes region_base (index 0) and memory_top (index 1); it is always ready and
// is meant to be used only while no request is in flight. Writing memory_top
// frees every frame; other indexes are ignored.
// The used marks live in a synchronous memory of 32 words of 32 marks, read one
// word per cycle with a read-modify-write of the word that holds the hit.
// A request is captured on acceptance, checked in PREP, evaluated in EVAL, and
// its result is loaded into the output register from RESP. An allocate scans one
// word per cycle from the bottom of the region, reading 1 to 32 words until it
// finds the lowest free frame or passes the frame count. A bad release address
// or an allocate with no managed frames goes from PREP straight to RESP.
// One request is processed at a time; the block is ready again once the previous
// result sits in the output register, even if rsp is stalled.
// A stalled rsp holds its result and the block waits before loading another.
// Reset restores the register defaults and marks every frame free at once
// (per-word valid bits), so no clearing pass is needed.
module page_frame_allocator_unit (
    input logic      clk,
    input logic      rst_n,
    pfa_req_if.sink  req,
    pfa_rsp_if.source rsp,
    pfa_cfg_if.sink  cfg
);
    import pfa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    // Configuration registers.
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] top_reg;

    // Control and captured request.
    logic [1:0]            state_reg,  state_next;
    logic                  mode_reg;
    logic [FLAGS_W-1:0]    flags_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [COUNT_W-1:0]    n_reg;
    logic [WORD_IDX_W-1:0] word_reg,   word_next;
    logic [BIT_IDX_W-1:0]  bit_reg,    bit_next;
    logic [ADDR_W-1:0]     res_entry_reg, res_entry_next;
    status_t               res_status_reg, res_status_next;

    // Output register.
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_entry_reg;
    status_t           out_status_reg;

    // Mark memory and its per-word valid bits.
    logic [WORD_BITS-1:0]  mem [WORDS];
    logic [WORDS-1:0]      row_valid_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_BITS-1:0]  wr_data;

    logic                  req_fire;
    logic                  cfg_fire;
    logic                  out_load;
    logic [ADDR_W-1:0]     abase;
    logic [ADDR_W-1:0]     top_diff;
    logic [PAGES_W-1:0]    top_pages;
    logic [COUNT_W-1:0]    n_comb;
    logic [ADDR_W-1:0]     rel_off;
    logic [PAGES_W-1:0]    rel_page;
    logic                  rel_bad;
    logic [WORD_BITS-1:0]  cur_word;
    logic [WORD_BITS-1:0]  lim_mask;
    logic [WORD_BITS-1:0]  busy_word;
    logic                  free_found;
    logic [BIT_IDX_W-1:0]  free_pos;
    logic [WORD_IDX_W:0]   word_inc;
    logic                  more_words;
    logic [FRAME_IDX_W-1:0] hit_frame;

    assign req_fire = req.valid && req.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // Frame count of the region, clipped to the maximum.
    assign abase     = {base_reg[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
    assign top_diff  = top_reg - abase;
    assign top_pages = top_diff[ADDR_W-1:PAGE_SHIFT];

    always_comb
    begin
        if (top_reg <= abase)
            n_comb = '0;
        else if (top_pages > PAGES_W'(MAX_FRAMES))
            n_comb = COUNT_W'(MAX_FRAMES);
        else
            n_comb = top_pages[COUNT_W-1:0];
    end

    // Release address checks: alignment, lower bound, upper bound.
    assign rel_off  = addr_reg - abase;
    assign rel_page = rel_off[ADDR_W-1:PAGE_SHIFT];
    assign rel_bad  = (addr_reg[PAGE_SHIFT-1:0] != '0) || (addr_reg < abase)
                      || (rel_page >= PAGES_W'(n_reg));

    // A word that was never written since the last clear reads as all free.
    assign cur_word = rd_valid_reg ? rd_data_reg : '0;

    // Frames at or past the frame count are treated as used.
    always_comb
    begin
        if ({1'b0, word_reg} < n_reg[COUNT_W-1:BIT_IDX_W])
            lim_mask = '1;
        else if ({1'b0, word_reg} == n_reg[COUNT_W-1:BIT_IDX_W])
            lim_mask = ~({WORD_BITS{1'b1}} << n_reg[BIT_IDX_W-1:0]);
        else
            lim_mask = '0;
    end

    assign busy_word = cur_word | ~lim_mask;

    // Lowest free mark in the current word.
    always_comb
    begin
        free_found = 1'b0;
        free_pos   = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!busy_word[j])
            begin
                free_found = 1'b1;
                free_pos   = BIT_IDX_W'(j);
            end
        end
    end

    assign word_inc   = {1'b0, word_reg} + (WORD_IDX_W+1)'(1);
    assign more_words = ({word_inc, BIT_IDX_W'(0)} < n_reg);
    assign hit_frame  = {word_reg, free_pos};

    // Sequencer: next state, memory access and result.
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = word_reg;
        wr_en           = 1'b0;
        wr_data         = cur_word;
        out_load        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                res_entry_next = '0;
                if (mode_reg == MODE_ALLOC)
                begin
                    if (n_reg == '0)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        word_next  = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_EVAL;
                    end
                end
                else if (rel_bad)
                begin
                    res_status_next = ST_BADADDR;
                    state_next      = S_RESP;
                end
                else
                begin
                    word_next  = rel_page[FRAME_IDX_W-1:BIT_IDX_W];
                    bit_next   = rel_page[BIT_IDX_W-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = rel_page[FRAME_IDX_W-1:BIT_IDX_W];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (free_found)
                    begin
                        wr_en             = 1'b1;
                        wr_data           = cur_word | (WORD_BITS'(1) << free_pos);
                        res_entry_next    = (abase + ADDR_W'({hit_frame, PAGE_SHIFT'(0)}))
                                            | PRESENT_BIT | ADDR_W'(flags_reg);
                        res_status_next   = ST_OK;
                        state_next        = S_RESP;
                    end
                    else if (more_words)
                    begin
                        word_next = word_inc[WORD_IDX_W-1:0];
                        rd_en     = 1'b1;
                        rd_addr   = word_inc[WORD_IDX_W-1:0];
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESP;
                    end
                end
                else
                begin
                    if (cur_word[bit_reg])
                    begin
                        wr_en           = 1'b1;
                        wr_data         = cur_word & ~(WORD_BITS'(1) << bit_reg);
                        res_status_next = ST_OK;
                    end
                    else
                    begin
                        res_status_next = ST_NOTUSED;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            base_reg      <= REGION_BASE_RST;
            top_reg       <= MEMORY_TOP_RST;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg_fire && cfg.index == CFG_REGION_BASE)
                base_reg <= cfg.data;
            if (cfg_fire && cfg.index == CFG_MEMORY_TOP)
            begin
                top_reg       <= cfg.data;
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[word_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg  <= req.mode;
            flags_reg <= req.entry_flags;
            addr_reg  <= req.page_address;
            n_reg     <= n_comb;
        end
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_entry_reg  <= res_entry_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Mark memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[word_reg] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.table_entry = out_entry_reg;
    assign rsp.status      = out_status_reg;

    // The memory is only written while a word is being evaluated.
    a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_EVAL)
        else $error("mark memory written outside evaluation");

    // A write always changes exactly one mark.
    a_write_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> $countones(wr_data ^ cur_word) == 1)
        else $error("read-modify-write changed other than one mark");

    // An allocate scan never reads past the managed frames.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && mode_reg == MODE_ALLOC)
        |-> {word_reg, BIT_IDX_W'(0)} < n_reg)
        else $error("allocate scan beyond the frame count");

    // A failed request carries a zero entry.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> out_entry_reg == '0)
        else $error("failed request with nonzero entry");

    // A result is loaded only after a request went through evaluation or checks.
    a_load_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> $past(state_reg) == S_PREP || $past(state_reg) == S_EVAL
                     || $past(state_reg) == S_RESP)
        else $error("result loaded without a request");

endmodule

### sim/tb_page_frame_allocator_unit.sv
`timescale 1ns / 1ps

module tb_page_frame_allocator_unit;
    import pfa_pkg::*;

    // The block ignores writes to these register indexes.
    localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
    localparam cfg_idx_t CFG_SPARE_HI = 2'd3;

    localparam logic [ADDR_W-1:0] PAGE_MASK  = FRAME_BYTES - 1;
    localparam int                IDLE_PCT   = 34;
    localparam int                HOLD_CYCLES = 300;
    localparam int                STALL_LIMIT = 3000;
    localparam int                MAX_REPORTS = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] entry;
        status_t           status;
    } frame_result_t;

    typedef struct packed {
        logic               mode;
        logic [FLAGS_W-1:0] flags;
        logic [ADDR_W-1:0]  addr;
    } frame_request_t;

    // Mirror of the allocator: register copies, used marks and the expected results.
    class frame_scoreboard;
        logic [ADDR_W-1:0] base_reg;
        logic [ADDR_W-1:0] top_reg;
        bit                used [MAX_FRAMES];
        frame_result_t     expected_q [$];
        int                errors;

        function void reset_state();
            base_reg = REGION_BASE_RST;
            top_reg  = MEMORY_TOP_RST;
            foreach (used[i]) used[i] = 1'b0;
            expected_q.delete();
            errors = 0;
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function logic [ADDR_W-1:0] aligned_base();
            return base_reg & ~PAGE_MASK;
        endfunction

        // Frames between the aligned base and the top, clipped to the mark store.
        function logic [ADDR_W-1:0] frame_total();
            logic [ADDR_W-1:0] b;
            logic [ADDR_W-1:0] n;
            b = aligned_base();
            if (top_reg <= b)
                return '0;
            n = (top_reg - b) >> PAGE_SHIFT;
            if (n > MAX_FRAMES)
                n = MAX_FRAMES;
            return n;
        endfunction

        function void write_register(cfg_idx_t idx, logic [ADDR_W-1:0] data);
            if (idx == CFG_REGION_BASE) begin
                base_reg = data;
            end
            else if (idx == CFG_MEMORY_TOP) begin
                top_reg = data;
                foreach (used[i]) used[i] = 1'b0;
            end
        endfunction

        // Work out the answer to an accepted request and update the marks.
        function void note_request(logic mode, logic [FLAGS_W-1:0] flags,
                                   logic [ADDR_W-1:0] addr);
            frame_result_t     res;
            logic [ADDR_W-1:0] b;
            logic [ADDR_W-1:0] n;
            logic [ADDR_W-1:0] idx;
            b = aligned_base();
            n = frame_total();
            res.entry = '0;
            if (mode == MODE_ALLOC) begin
                res.status = ST_FULL;
                for (int i = 0; i < n; i++) begin
                    if (!used[i]) begin
                        used[i] = 1'b1;
                        res.entry = (b + (ADDR_W'(i) << PAGE_SHIFT)) | PRESENT_BIT
                                    | ADDR_W'(flags);
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            else if ((addr & PAGE_MASK) != 0 || addr < b) begin
                res.status = ST_BADADDR;
            end
            else begin
                idx = (addr - b) >> PAGE_SHIFT;
                if (idx >= n) begin
                    res.status = ST_BADADDR;
                end
                else if (!used[idx]) begin
                    res.status = ST_NOTUSED;
                end
                else begin
                    used[idx] = 1'b0;
                    res.status = ST_OK;
                end
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [ADDR_W-1:0] entry, status_t status);
            frame_result_t want;
            if (expected_q.size() == 0) begin
                flag_error($sformatf("Unexpected result: table_entry=%h status=%0d",
                                     entry, status));
                return;
            end
            want = expected_q.pop_front();
            if (entry !== want.entry || status !== want.status)
                flag_error($sformatf(
                    "Mismatch: table_entry exp %h got %h, status exp %0d got %0d",
                    want.entry, entry, want.status, status));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_drained();
            if (expected_q.size() != 0)
                flag_error($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    bit   holdoff_armed;
    int   stall_cycles;

    frame_scoreboard sb;

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();
    pfa_cfg_if cfg_ch ();

    page_frame_allocator_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Record every handshake at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_register(cfg_ch.index, cfg_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.table_entry, rsp_ch.status);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.mode, req_ch.entry_flags, req_ch.page_address);
        end
    end

    // Result side: random back-pressure, plus one long hold-off when armed.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_armed) begin
                holdoff_armed = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one request, with random idle cycles ahead of it. Called at a falling edge.
    task automatic issue_request(input frame_request_t rq);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= rq.mode;
        req_ch.entry_flags  <= rq.flags;
        req_ch.page_address <= rq.addr;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_alloc(input logic [FLAGS_W-1:0] flags);
        issue_request('{MODE_ALLOC, flags, ADDR_W'($urandom)});
    endtask

    task automatic send_release(input logic [ADDR_W-1:0] addr);
        issue_request('{MODE_RELEASE, FLAGS_W'($urandom), addr});
    endtask

    // Write a register once every result is in and the block has gone quiet.
    task automatic write_register(input cfg_idx_t idx, input logic [ADDR_W-1:0] data);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Release addresses: mostly frames in use, then random frames in range, then bad addresses.
    function automatic logic [ADDR_W-1:0] pick_release_address();
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] n;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] probe;
        int                r;
        b = sb.aligned_base();
        n = sb.frame_total();
        r = $urandom_range(99);
        if (n != 0 && r < 55) begin
            idx = $urandom_range(n - 1);
            for (int k = 0; k < n; k++) begin
                probe = (idx + k) % n;
                if (sb.used[probe])
                    return b + (probe << PAGE_SHIFT);
            end
            return b + (idx << PAGE_SHIFT);
        end
        if (n != 0 && r < 70)
            return b + (ADDR_W'($urandom_range(n - 1)) << PAGE_SHIFT);
        if (r < 80)
            return b + (ADDR_W'($urandom_range(n)) << PAGE_SHIFT)
                   + ADDR_W'($urandom_range(FRAME_BYTES - 1, 1));
        if (r < 87)
            return b - (ADDR_W'($urandom_range(4, 1)) << PAGE_SHIFT);
        if (r < 94)
            return b + ((n + ADDR_W'($urandom_range(3))) << PAGE_SHIFT);
        return ADDR_W'($urandom);
    endfunction

    task automatic run_mixed(input int count, input int alloc_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < alloc_pct)
                send_alloc(FLAGS_W'($urandom));
            else
                send_release(pick_release_address());
        end
    endtask

    // A region with a random base and a small random frame count.
    task automatic random_region(input int max_frames);
        logic [ADDR_W-1:0] b;
        logic [ADDR_W:0]   t;
        b = ADDR_W'($urandom);
        t = {1'b0, b & ~PAGE_MASK}
            + ((ADDR_W+1)'($urandom_range(max_frames, 1)) << PAGE_SHIFT)
            + (ADDR_W+1)'($urandom_range(FRAME_BYTES - 1));
        if (t[ADDR_W])
            t = {1'b0, {ADDR_W{1'b1}}};
        write_register(CFG_REGION_BASE, b);
        write_register(CFG_MEMORY_TOP, t[ADDR_W-1:0]);
    endtask

    task automatic region_phase(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] t,
                                input int count);
        write_register(CFG_REGION_BASE, b);
        write_register(CFG_MEMORY_TOP, t);
        run_mixed(count, 55);
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        steady        = 1'b0;
        holdoff_armed = 1'b0;
        rst_n         = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_ALLOC;
        req_ch.entry_flags  = '0;
        req_ch.page_address = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_REGION_BASE;
        cfg_ch.data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default region: flag extremes, reuse of a freed frame, each bad address kind.
        send_alloc(12'h000);
        send_alloc(12'hFFF);
        send_alloc(12'hAAA);
        send_alloc(12'h555);
        send_release(32'h0010_0000);
        send_release(32'h0010_0000);
        send_alloc(12'h001);
        send_release(32'h0010_0800);
        send_release(32'h000F_F000);
        send_release(32'h0050_0000);
        send_release(32'h004F_F000);
        send_release(32'hFFFF_FFFF);
        send_release(32'h0000_0000);
        send_release(32'h0010_1000);

        // Top at zero, below the base: nothing is managed.
        write_register(CFG_MEMORY_TOP, 32'h0000_0000);
        send_alloc(12'h7FF);
        send_release(32'h0010_0000);

        // Unaligned base and a partial top page leave two frames.
        write_register(CFG_REGION_BASE, 32'h0000_3ABC);
        write_register(CFG_MEMORY_TOP, 32'h0000_5FFF);
        send_alloc(12'h123);
        send_alloc(12'h800);
        send_alloc(12'h0F0);
        send_release(32'h0000_5000);

        // A new base keeps the marks and moves the addresses.
        write_register(CFG_REGION_BASE, 32'h0000_2000);
        send_alloc(12'h00F);
        send_release(32'h0000_2000);

        // Spare register indexes change nothing.
        write_register(CFG_SPARE_LO, ADDR_W'($urandom));
        write_register(CFG_SPARE_HI, ADDR_W'($urandom));
        send_alloc(12'hF00);

        // Fixed corner regions, then random small regions with a base move halfway.
        region_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 40);
        region_phase(32'h0000_0000, 32'h0001_0000, 90);
        region_phase(32'hFFFF_0ABC, 32'hFFFF_FFFF, 90);
        for (int p = 0; p < 4; p++) begin
            random_region(64);
            run_mixed(45, 55);
            write_register(CFG_REGION_BASE,
                           sb.base_reg + (ADDR_W'($urandom_range(8)) << PAGE_SHIFT));
            run_mixed(45, 50);
        end

        // Full store: fill every frame past the clip while the result side holds off.
        write_register(CFG_REGION_BASE, 32'h4000_0000);
        write_register(CFG_MEMORY_TOP, 32'hFFFF_FFFF);
        steady        = 1'b1;
        holdoff_armed = 1'b1;
        for (int i = 0; i < 1030; i++) begin
            if (i == 400)
                steady = 1'b0;
            send_alloc(FLAGS_W'($urandom));
        end
        run_mixed(70, 50);

        // Drain, then allow the block a little longer for stray results.
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
